// File: src/sha256_pkg.sv
// Shared types, constants and functions for the SHA-256 stream hasher.
// No dependencies; imported by every module of the block.
package sha256_pkg;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;

    // control from the sequencer to the schedule line
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       step;
    } t_sched_ctl;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic       load;
        logic       step;
        logic       add;
        logic       init;
        logic [5:0] rnd;
    } t_round_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: src/sha256_sched.sv
// Block buffer and message schedule: a 16-word shift line that takes bytes
// while filling and expands one schedule word per round. Uses sha256_pkg.
module sha256_sched
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    output logic [31:0] o_w
);

    logic [511:0] r_blk;
    logic [31:0]  w0, w1, w9, w14;
    logic [31:0]  n_word;

    // word j of the window sits at bits 511-32j
    assign w0  = r_blk[511 -: 32];
    assign w1  = r_blk[479 -: 32];
    assign w9  = r_blk[223 -: 32];
    assign w14 = r_blk[63 -: 32];

    assign n_word = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
    assign o_w    = w0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            r_blk <= {r_blk[503:0], i_ctl.byte_val};
        end else if (i_ctl.step) begin
            r_blk <= {r_blk[479:0], n_word};
        end
    end

endmodule

// File: src/sha256_round.sv
// Compression round unit: working variables a..h, one round per step, and
// the eight chaining words updated after the last round. Uses sha256_pkg.
module sha256_round
    import sha256_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_round_ctl       i_ctl,
    input  logic [31:0]      i_w,
    output logic [7:0][31:0] o_h
);

    logic [7:0][31:0] r_h;
    logic [7:0][31:0] r_v;
    logic [31:0]      t1, t2, ch, maj;

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sigma1(r_v[4]) + ch + RoundK[i_ctl.rnd] + i_w;
    assign t2  = big_sigma0(r_v[0]) + maj;
    assign o_h = r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= InitH[i];
            end
        end else if (i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= InitH[i];
            end
        end else if (i_ctl.add) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= r_h;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

endmodule

// File: src/sha256_stream_hasher.sv
// SHA-256 over a byte stream: sequencer, padding and digest output.
// Depends on sha256_pkg, sha256_sched and sha256_round.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------
//   in      | in  | i_valid / o_ready    | i_data_byte, i_has_byte, i_is_last
//   out     | out | o_valid / i_ready    | o_digest_word, o_word_index, o_last_word
//
// A word that does not complete a block leaves the hasher ready for the next. Completing a block
// adds 64 rounds through the single round unit plus the chaining add.
// A last word then pads byte-serially (one pad or length byte per cycle outside compression, up to
// 64 per block, plus one turnaround step before the 8 length bytes),
// compresses one or two blocks, and presents 8 digest words.
// Synchronous active-low reset restores the initial hash values; no clearing
// pass is needed. o_ready is low after a block-completing word until its
// compression ends, and after a last word until the final digest word is
// taken; a stalled output simply holds.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_LEN,
        S_OUT
    } t_state;

    t_state           r_state, r_ret;
    logic [5:0]       r_fill;
    logic [60:0]      r_len;
    logic [5:0]       r_rnd;
    logic [2:0]       r_out_idx;
    logic             r_first;

    t_sched_ctl       sched_ctl;
    t_round_ctl       round_ctl;
    logic [31:0]      w_cur;
    logic [7:0][31:0] h_words;
    logic [63:0]      bit_len;
    logic [5:0]       len_ofs;
    logic             pad_shift;

    assign bit_len   = {r_len, 3'b000};
    // length bytes go out most significant first while fill runs 56..63
    assign len_ofs   = {~r_fill[2:0], 3'b000};
    assign pad_shift = r_first || (r_fill != 6'd56);

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = h_words[r_out_idx];
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == 3'd7);

    always_comb begin
        sched_ctl       = '0;
        round_ctl       = '0;
        round_ctl.rnd   = r_rnd;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_has_byte) begin
                    sched_ctl.shift_byte = 1'b1;
                    sched_ctl.byte_val   = i_data_byte;
                    round_ctl.load       = (r_fill == 6'd63);
                end
            end
            S_PAD: begin
                if (pad_shift) begin
                    sched_ctl.shift_byte = 1'b1;
                    sched_ctl.byte_val   = r_first ? PadByte : 8'h00;
                    round_ctl.load       = (r_fill == 6'd63);
                end
            end
            S_LEN: begin
                sched_ctl.shift_byte = 1'b1;
                sched_ctl.byte_val   = bit_len[len_ofs +: 8];
                round_ctl.load       = (r_fill == 6'd63);
            end
            S_ROUND: begin
                sched_ctl.step = 1'b1;
                round_ctl.step = 1'b1;
            end
            S_ADD: begin
                round_ctl.add = 1'b1;
            end
            S_OUT: begin
                round_ctl.init = i_ready && (r_out_idx == 3'd7);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_fill    <= '0;
            r_len     <= '0;
            r_rnd     <= '0;
            r_out_idx <= '0;
            r_first   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_first <= i_is_last;
                        if (i_has_byte) begin
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + 61'd1;
                        end
                        if (i_has_byte && (r_fill == 6'd63)) begin
                            r_state <= S_ROUND;
                            r_rnd   <= '0;
                            r_ret   <= i_is_last ? S_PAD : S_IDLE;
                        end else if (i_is_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (pad_shift) begin
                        r_first <= 1'b0;
                        r_fill  <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_state <= S_ROUND;
                            r_rnd   <= '0;
                            r_ret   <= S_PAD;
                        end
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_state <= S_ROUND;
                        r_rnd   <= '0;
                        r_ret   <= S_OUT;
                    end
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_state   <= r_ret;
                    r_out_idx <= '0;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_len   <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    sha256_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w_cur)
    );

    sha256_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (round_ctl),
        .i_w     (w_cur),
        .o_h     (h_words)
    );

endmodule

// File: bench/tb.sv
// Testbench for sha256_stream_hasher: random byte messages in, digest words out.
// A scoreboard class hashes every accepted word on its own and checks each digest word.
// Depends only on the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb;

    localparam bit [31:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] IV_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [7:0] PAD_MARK = 8'h80;
    localparam int BLK_BYTES = 64;
    localparam int LEN_OFFSET = 56;   // first byte of the bit-length field
    localparam int N_ITEMS = 470;
    localparam int IDLE_PCT = 32;
    localparam int EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    class sha_digest_board;
        typedef struct {
            bit [31:0] word;
            bit [2:0]  idx;
            bit        lastw;
        } t_digest_word;

        bit [31:0]    chain [8];
        bit [7:0]     blk [BLK_BYTES];
        int unsigned  fill;
        bit [60:0]    msg_len;
        t_digest_word pending_digest [$];
        int           errors;

        function new();
            chain = IV_H;
            fill = 0;
            msg_len = '0;
            errors = 0;
        endfunction

        function bit [31:0] ror(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            bit [31:0] w [64];
            bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            int i;
            for (i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (i = 16; i < 64; i++) begin
                s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                        chain[4], chain[5], chain[6], chain[7]};
            for (i = 0; i < 64; i++) begin
                t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                     + RND_K[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g;
                g = f;
                f = e;
                e = d + t1;
                d = c;
                c = b;
                b = a;
                a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        // one accepted input word
        function void absorb_item(bit [7:0] data, bit has_byte, bit is_last);
            bit [63:0] bit_len;
            t_digest_word dw;
            int i;
            if (has_byte) begin
                blk[fill] = data;
                fill = (fill + 1) % BLK_BYTES;
                msg_len = msg_len + 61'd1;
                if (fill == 0)
                    compress();
            end
            if (!is_last)
                return;
            bit_len = {msg_len, 3'b000};
            blk[fill] = PAD_MARK;
            for (i = fill + 1; i < BLK_BYTES; i++)
                blk[i] = 8'h00;
            // no room for the length: it goes into an extra block
            if (fill >= LEN_OFFSET) begin
                compress();
                for (i = 0; i < LEN_OFFSET; i++)
                    blk[i] = 8'h00;
            end
            for (i = 0; i < 8; i++)
                blk[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
            compress();
            for (i = 0; i < 8; i++) begin
                dw.word = chain[i];
                dw.idx = i[2:0];
                dw.lastw = (i == 7);
                pending_digest.push_back(dw);
            end
            chain = IV_H;
            fill = 0;
            msg_len = '0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(bit [31:0] word, bit [2:0] idx, bit lastw);
            t_digest_word dw;
            if (pending_digest.size() == 0) begin
                report($sformatf("unexpected digest word %h idx %0d", word, idx));
                return;
            end
            dw = pending_digest.pop_front();
            if (word !== dw.word)
                report($sformatf("digest word idx %0d: got %h, want %h", dw.idx, word, dw.word));
            if (idx !== dw.idx)
                report($sformatf("word index: got %0d, want %0d", idx, dw.idx));
            if (lastw !== dw.lastw)
                report($sformatf("last flag at idx %0d: got %0b, want %0b",
                                 dw.idx, lastw, dw.lastw));
        endtask

        function int pending();
            return pending_digest.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_is_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha_digest_board sb = new();
    int  n_sent = 0;
    bit  calm = 1'b0;

    sha256_stream_hasher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // digest side: random back-pressure, checked at the edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_word(o_digest_word, o_word_index, o_last_word);
            i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic is_last);
        calm = (n_sent >= 200 && n_sent < 300);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                i_data_byte <= 8'($urandom);
                i_has_byte <= 1'($urandom);
                i_is_last <= 1'($urandom);
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_has_byte <= has_byte;
        i_is_last <= is_last;
        do @(posedge i_clk); while (!o_ready);
        sb.absorb_item(data, has_byte, is_last);
        n_sent++;
    endtask

    task automatic drain_digests();
        if (sb.pending() != 0) begin
            i_valid <= 1'b0;
            while (sb.pending() != 0)
                @(posedge i_clk);
        end
    endtask

    // len message bytes; the final byte carries the end mark when tail_byte is set
    task automatic send_message(input int len, input bit tail_byte);
        int k;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);   // ignored word
            send_item(8'($urandom), 1'b1, tail_byte && (k == len - 1));
        end
        if (!tail_byte || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message
        send_item(8'h00, 1'b0, 1'b1);
        // "abc", end mark on the byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // extreme bytes, ignored word mid-message, byteless end
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h3c, 1'b1, 1'b1);
        drain_digests();

        while (n_sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(1, 12);
                5:             len = 0;
                6, 7:          len = EDGE_LENS[$urandom_range(0, 9)];
                8:             len = $urandom_range(13, 54);
                default:       len = $urandom_range(52, 70);
            endcase
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                drain_digests();
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
